/* rtl/bhs_pkg.sv */
// bhs_pkg: shared sizes, codes and types for the bucketed hash set engine
// no dependencies; used by bhs_hash, bhs_match, bucketed_hash_set_engine and tb
package bhs_pkg;

	// set geometry
	localparam int NUM_BUCKETS = 64;
	localparam int WAYS        = 8;
	localparam int SLOT_TOTAL  = NUM_BUCKETS * WAYS;

	// field widths
	localparam int KEY_W   = 64;
	localparam int ACT_W   = 2;
	localparam int COUNT_W = 10;

	// bucket row: WAYS keys in the low bits, WAYS valid bits above them
	localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int ROW_W = WAYS * (KEY_W + 1);
	localparam int VLD_LSB = WAYS * KEY_W;

	// bucket selection: a mask for power-of-two bucket counts, else a digit-serial remainder
	localparam bit BUCKET_POW2  = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;
	localparam int HASH_DIGIT_W = 4;
	localparam int HASH_STEPS   = KEY_W / HASH_DIGIT_W;
	localparam int STEP_W       = $clog2(HASH_STEPS);

	// request actions; the spare code behaves as a lookup
	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_LOOKUP = 2'd2
	} action_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_UPDATE
	} state_t;

	// outcome of one bucket compare
	typedef struct packed {
		logic found;
		logic rejected;
		logic wr;
		logic cnt_inc;
		logic cnt_dec;
	} match_t;

endpackage

/* rtl/bhs_ram.sv */
// bhs_ram: generic single-write, single-read synchronous ram with registered read
// no dependencies
module bhs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                           wr_data,
	input  logic                                       rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                           rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/bhs_hash.sv */
// bhs_hash: bucket index from a key (key modulo the bucket count)
// depends on bhs_pkg
module bhs_hash (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [bhs_pkg::KEY_W-1:0] key,
	output logic                      done,
	output logic [bhs_pkg::BKT_W-1:0] bucket
);

	generate
		if (bhs_pkg::BUCKET_POW2) begin : g_mask
			// power-of-two bucket count: the low key bits, ready at once
			assign bucket = key[bhs_pkg::BKT_W-1:0];
			assign done   = start;
		end else begin : g_rem
			localparam logic [bhs_pkg::BKT_W:0] NB = (bhs_pkg::BKT_W + 1)'(bhs_pkg::NUM_BUCKETS);
			localparam logic [bhs_pkg::STEP_W-1:0] LAST_STEP =
				bhs_pkg::STEP_W'(bhs_pkg::HASH_STEPS - 1);

			logic [bhs_pkg::KEY_W-1:0]  key_sh_q;
			logic [bhs_pkg::BKT_W-1:0]  rem_q;
			logic [bhs_pkg::STEP_W-1:0] step_q;
			logic                       busy_q;
			logic [bhs_pkg::BKT_W-1:0]  rem_nxt;

			// one digit of restoring remainder, most significant bits first
			always_comb begin
				logic [bhs_pkg::BKT_W:0] t;
				rem_nxt = rem_q;
				for (int j = 0; j < bhs_pkg::HASH_DIGIT_W; j++) begin
					t = {rem_nxt, key_sh_q[bhs_pkg::KEY_W-1-j]};
					if (t >= NB) begin
						t = t - NB;
					end
					rem_nxt = t[bhs_pkg::BKT_W-1:0];
				end
			end

			// digit sequencing
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
					step_q <= '0;
				end else if (start) begin
					busy_q <= 1'b1;
					step_q <= '0;
				end else if (busy_q) begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						busy_q <= 1'b0;
					end
				end
			end

			// remainder and key shift register
			always_ff @(posedge clk) begin
				if (start) begin
					key_sh_q <= key;
					rem_q    <= '0;
				end else if (busy_q) begin
					key_sh_q <= key_sh_q << bhs_pkg::HASH_DIGIT_W;
					rem_q    <= rem_nxt;
				end
			end

			assign bucket = rem_nxt;
			assign done   = busy_q && (step_q == LAST_STEP);
		end
	endgenerate

endmodule

/* rtl/bhs_match.sv */
// bhs_match: compares a bucket row with the request key and builds the row to write back
// depends on bhs_pkg
module bhs_match (
	input  logic [bhs_pkg::ROW_W-1:0] row_in,
	input  logic [bhs_pkg::KEY_W-1:0] key,
	input  logic [bhs_pkg::ACT_W-1:0] action,
	output logic [bhs_pkg::ROW_W-1:0] row_out,
	output bhs_pkg::match_t           res
);

	logic [bhs_pkg::WAYS-1:0] valid;
	logic [bhs_pkg::WAYS-1:0] eq_vec;
	logic [bhs_pkg::WAYS-1:0] hit_oh;
	logic [bhs_pkg::WAYS-1:0] free_oh;
	logic                     hit;
	logic                     has_free;
	logic                     do_ins;
	logic                     do_rem;

	assign valid = row_in[bhs_pkg::VLD_LSB +: bhs_pkg::WAYS];

	// parallel key compare over the valid ways
	always_comb begin
		for (int w = 0; w < bhs_pkg::WAYS; w++) begin
			eq_vec[w] = valid[w] && (row_in[w*bhs_pkg::KEY_W +: bhs_pkg::KEY_W] == key);
		end
	end

	// lowest matching way and lowest free way
	assign hit_oh   = eq_vec & (~eq_vec + 1'b1);
	assign free_oh  = ~valid & (valid + 1'b1);
	assign hit      = |eq_vec;
	assign has_free = ~&valid;

	assign do_ins = (action == bhs_pkg::ACT_INSERT) && !hit && has_free;
	assign do_rem = (action == bhs_pkg::ACT_REMOVE) && hit;

	// outcome flags
	always_comb begin
		res.found    = hit;
		res.rejected = (action == bhs_pkg::ACT_INSERT) && !hit && !has_free;
		res.wr       = do_ins || do_rem;
		res.cnt_inc  = do_ins;
		res.cnt_dec  = do_rem;
	end

	// updated row: new key into the free way, valid bit set or cleared
	always_comb begin
		row_out = row_in;
		for (int w = 0; w < bhs_pkg::WAYS; w++) begin
			if (do_ins && free_oh[w]) begin
				row_out[w*bhs_pkg::KEY_W +: bhs_pkg::KEY_W] = key;
				row_out[bhs_pkg::VLD_LSB + w]               = 1'b1;
			end
			if (do_rem && hit_oh[w]) begin
				row_out[bhs_pkg::VLD_LSB + w] = 1'b0;
			end
		end
	end

endmodule

/* rtl/bucketed_hash_set_engine.sv */
// bucketed_hash_set_engine: top level, sequencer, element count and result register
// depends on bhs_pkg, bhs_ram, bhs_hash, bhs_match
//
// Set of 64-bit keys in NUM_BUCKETS buckets of WAYS slots; a key lives in bucket
// key mod NUM_BUCKETS. Each request reads its bucket row from one ram, compares
// all ways at once and writes the row back while the result is registered; when
// NUM_BUCKETS is not a power of two, the row read first waits on a remainder unit
// that takes four key bits a cycle. One request is in work at a time; a new
// request is taken while the previous result waits on the output. After reset the
// ram valid bits are cleared one row a cycle, and s_tready stays low until that
// pass ends. An insert into a full bucket is dropped and flagged; entry_count gives
// the keys held afterwards.
module bucketed_hash_set_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] key
	input  logic [1:0]  s_tuser,   // [1:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [0] found, [1] rejected_full, [11:2] entry_count, rest zero
);

	localparam logic [bhs_pkg::BKT_W-1:0] LAST_ROW = bhs_pkg::BKT_W'(bhs_pkg::NUM_BUCKETS - 1);

	bhs_pkg::state_t             state_q, state_nxt;
	logic [bhs_pkg::BKT_W-1:0]   clr_q;
	logic [bhs_pkg::BKT_W-1:0]   bkt_q;
	logic [bhs_pkg::KEY_W-1:0]   key_q;
	logic [bhs_pkg::ACT_W-1:0]   act_q;
	logic [bhs_pkg::COUNT_W-1:0] count_q, count_nxt;
	logic                        m_tvalid_q;
	logic [15:0]                 m_tdata_q;

	logic                        accept;
	logic                        out_free;
	logic                        hash_done;
	logic [bhs_pkg::BKT_W-1:0]   hash_bucket;
	logic                        rd_en;
	logic                        wr_en;
	logic                        commit;
	logic [bhs_pkg::BKT_W-1:0]   wr_addr;
	logic [bhs_pkg::ROW_W-1:0]   wr_data;
	logic [bhs_pkg::ROW_W-1:0]   rd_row;
	logic [bhs_pkg::ROW_W-1:0]   new_row;
	bhs_pkg::match_t             res;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// bucket index
	bhs_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.key    (s_tdata),
		.done   (hash_done),
		.bucket (hash_bucket)
	);

	// bucket rows: keys and valid bits
	bhs_ram #(
		.WIDTH (bhs_pkg::ROW_W),
		.DEPTH (bhs_pkg::NUM_BUCKETS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (hash_bucket),
		.rd_data (rd_row)
	);

	// compare and row update
	bhs_match u_match (
		.row_in  (rd_row),
		.key     (key_q),
		.action  (act_q),
		.row_out (new_row),
		.res     (res)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			bhs_pkg::ST_CLEAR: begin
				if (clr_q == LAST_ROW) begin
					state_nxt = bhs_pkg::ST_IDLE;
				end
			end
			bhs_pkg::ST_IDLE: begin
				if (accept) begin
					state_nxt = hash_done ? bhs_pkg::ST_UPDATE : bhs_pkg::ST_HASH;
				end
			end
			bhs_pkg::ST_HASH: begin
				if (hash_done) begin
					state_nxt = bhs_pkg::ST_UPDATE;
				end
			end
			bhs_pkg::ST_UPDATE: begin
				if (out_free) begin
					state_nxt = bhs_pkg::ST_IDLE;
				end
			end
			default: state_nxt = bhs_pkg::ST_CLEAR;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		rd_en    = 1'b0;
		commit   = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = bkt_q;
		wr_data  = new_row;
		unique case (state_q)
			bhs_pkg::ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			bhs_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				rd_en    = accept && hash_done;
			end
			bhs_pkg::ST_HASH: begin
				rd_en = hash_done;
			end
			bhs_pkg::ST_UPDATE: begin
				commit = out_free;
				wr_en  = out_free && res.wr;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// count after this request, wrapping at the field width
	always_comb begin
		count_nxt = count_q;
		if (res.cnt_inc) begin
			count_nxt = count_q + 1'b1;
		end else if (res.cnt_dec) begin
			count_nxt = count_q - 1'b1;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bhs_pkg::ST_CLEAR;
			clr_q      <= '0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == bhs_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (commit) begin
				count_q    <= count_nxt;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= s_tdata;
			act_q <= s_tuser;
		end
		if (rd_en) begin
			bkt_q <= hash_bucket;
		end
		if (commit) begin
			m_tdata_q <= {4'b0000, count_nxt, res.rejected, res.found};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef NO_ASSERTIONS
	// the ram is never read and written in the same cycle
	a_no_rd_wr: assert property (@(posedge clk) disable iff (!arst_n) !(rd_en && wr_en))
		else $error("bucket row read and written together");

	// a result appears only out of the update state
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == bhs_pkg::ST_UPDATE))
		else $error("result raised outside update");

	// a rejected insert never reports the key as found
	a_rej_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && m_tdata_q[1] |-> !m_tdata_q[0])
		else $error("rejected and found together");

	// the count never exceeds the slot total
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(bhs_pkg::SLOT_TOTAL >= (1 << bhs_pkg::COUNT_W)) || (int'(count_q) <= bhs_pkg::SLOT_TOTAL))
		else $error("element count above slot total");
`endif

endmodule

/* tb/tb.sv */
// tb: self-checking testbench for the bucketed hash set engine
// depends on bhs_pkg and bucketed_hash_set_engine; drives stream requests, predicts every result
// from its own copy of the set and checks each returned result against it
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [bhs_pkg::ACT_W-1:0] ACT_SPARE = 2'd3;
	localparam int HOLD_CYCLES = 200;
	localparam int PAD_LSB = 2 + bhs_pkg::COUNT_W;

	typedef struct packed {
		logic                        found;
		logic                        rejected_full;
		logic [bhs_pkg::COUNT_W-1:0] entry_count;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [bhs_pkg::KEY_W-1:0] s_tdata = '0;
	logic [bhs_pkg::ACT_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;

	// expected set contents, mirrored bucket by bucket
	logic [bhs_pkg::KEY_W-1:0]   set_keys [bhs_pkg::NUM_BUCKETS][bhs_pkg::WAYS];
	bit                          set_valid [bhs_pkg::NUM_BUCKETS][bhs_pkg::WAYS];
	logic [bhs_pkg::COUNT_W-1:0] set_count = '0;

	outcome_t pending_outcomes [$];

	bit quiet = 1'b0;
	bit hold_req = 1'b0;
	int errors = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int drops_seen = 0;
	int hits_seen = 0;
	int peak_held = 0;

	bucketed_hash_set_engine uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	// apply one set operation to the mirror and return what the block should report
	function automatic outcome_t apply_set_op(logic [bhs_pkg::ACT_W-1:0] action,
		logic [bhs_pkg::KEY_W-1:0] key);
		outcome_t res;
		int bucket;
		int hit_way;
		int free_way;
		bucket = int'(key % bhs_pkg::NUM_BUCKETS);
		hit_way = -1;
		free_way = -1;
		for (int w = 0; w < bhs_pkg::WAYS; w++) begin
			if (set_valid[bucket][w]) begin
				if (hit_way < 0 && set_keys[bucket][w] == key)
					hit_way = w;
			end else if (free_way < 0) begin
				free_way = w;
			end
		end
		res.found = (hit_way >= 0);
		res.rejected_full = 1'b0;
		if (action == bhs_pkg::ACT_INSERT) begin
			if (hit_way < 0) begin
				if (free_way >= 0) begin
					set_keys[bucket][free_way] = key;
					set_valid[bucket][free_way] = 1'b1;
					set_count = set_count + 1'b1;
				end else begin
					res.rejected_full = 1'b1;
				end
			end
		end else if (action == bhs_pkg::ACT_REMOVE) begin
			if (hit_way >= 0) begin
				set_valid[bucket][hit_way] = 1'b0;
				set_count = set_count - 1'b1;
			end
		end
		res.entry_count = set_count;
		if (res.rejected_full)
			drops_seen++;
		if (res.found)
			hits_seen++;
		if (int'(set_count) > peak_held)
			peak_held = int'(set_count);
		return res;
	endfunction

	function automatic logic [bhs_pkg::KEY_W-1:0] compose_key(logic [bhs_pkg::KEY_W-1:0] tag,
		int bucket);
		return tag * bhs_pkg::NUM_BUCKETS + bucket;
	endfunction

	function automatic logic [bhs_pkg::KEY_W-1:0] random_key();
		return {$urandom, $urandom};
	endfunction

	// offer one request, wait for it to be taken, then maybe leave a gap
	task automatic send_request(logic [bhs_pkg::ACT_W-1:0] action,
		logic [bhs_pkg::KEY_W-1:0] key);
		s_tvalid <= 1'b1;
		s_tdata  <= key;
		s_tuser  <= action;
		do @(posedge clk); while (!s_tready);
		pending_outcomes.push_back(apply_set_op(action, key));
		requests_sent++;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
	endtask

	// receiver side: random stalls, a long hold-off on request, none at the end
	initial begin
		@(negedge clk);
		forever begin
			if (quiet) begin
				m_tready <= 1'b1;
				@(negedge clk);
			end else if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else if ($urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end
		end
	end

	// compare every accepted result with the oldest expectation
	always @(posedge clk) begin : result_check
		outcome_t want;
		logic [15:0] got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			results_checked++;
			if (pending_outcomes.size() == 0) begin
				errors++;
				$display("%0t: result expected none actual %h", $time, got);
			end else begin
				want = pending_outcomes.pop_front();
				if (got[0] !== want.found) begin
					errors++;
					$display("%0t: found expected %0d actual %0d", $time, want.found, got[0]);
				end
				if (got[1] !== want.rejected_full) begin
					errors++;
					$display("%0t: rejected_full expected %0d actual %0d",
						$time, want.rejected_full, got[1]);
				end
				if (got[PAD_LSB-1:2] !== want.entry_count) begin
					errors++;
					$display("%0t: entry_count expected %0d actual %0d",
						$time, want.entry_count, got[PAD_LSB-1:2]);
				end
				if (got[15:PAD_LSB] !== '0) begin
					errors++;
					$display("%0t: padding expected 0 actual %h", $time, got[15:PAD_LSB]);
				end
			end
		end
	end

	// key zero, all-ones key, duplicates, absent removes, spare code, one full bucket
	task automatic test_directed();
		send_request(bhs_pkg::ACT_LOOKUP, '0);
		send_request(bhs_pkg::ACT_INSERT, '0);
		send_request(bhs_pkg::ACT_INSERT, '0);
		send_request(bhs_pkg::ACT_LOOKUP, '0);
		send_request(bhs_pkg::ACT_REMOVE, '0);
		send_request(bhs_pkg::ACT_REMOVE, '0);
		send_request(bhs_pkg::ACT_INSERT, '1);
		send_request(ACT_SPARE, '1);
		send_request(bhs_pkg::ACT_LOOKUP, '1);
		send_request(bhs_pkg::ACT_REMOVE, '1);
		for (int w = 0; w < bhs_pkg::WAYS; w++)
			send_request(bhs_pkg::ACT_INSERT, compose_key((64'(w) << 50) | 64'(w), 5));
		send_request(bhs_pkg::ACT_INSERT, compose_key(64'd99, 5));
		send_request(bhs_pkg::ACT_INSERT, compose_key((64'd3 << 50) | 64'd3, 5));
		send_request(bhs_pkg::ACT_REMOVE, compose_key((64'd2 << 50) | 64'd2, 5));
		send_request(bhs_pkg::ACT_INSERT, compose_key(64'd99, 5));
		send_request(bhs_pkg::ACT_LOOKUP, compose_key(64'd99, 5));
	endtask

	// receiver stops for a long stretch while requests keep coming
	task automatic test_receiver_holdoff();
		hold_req = 1'b1;
		for (int i = 0; i < 12; i++)
			send_request(bhs_pkg::ACT_INSERT,
				compose_key(64'($urandom_range(0, 11)), $urandom_range(0, 3)));
	endtask

	// fill every slot of every bucket, then one insert more
	task automatic test_fill_to_capacity();
		for (int w = 0; w < bhs_pkg::WAYS; w++)
			for (int b = 0; b < bhs_pkg::NUM_BUCKETS; b++)
				send_request(bhs_pkg::ACT_INSERT, compose_key((random_key() << 8) | 64'(w), b));
		send_request(bhs_pkg::ACT_INSERT, random_key());
	endtask

	// one random request, mostly on keys that are held or crowd a few buckets
	task automatic send_random_request();
		logic [bhs_pkg::ACT_W-1:0] action;
		logic [bhs_pkg::KEY_W-1:0] key;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			action = bhs_pkg::ACT_INSERT;
		else if (pick < 75)
			action = bhs_pkg::ACT_REMOVE;
		else if (pick < 95)
			action = bhs_pkg::ACT_LOOKUP;
		else
			action = ACT_SPARE;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			key = set_keys[$urandom_range(0, bhs_pkg::NUM_BUCKETS-1)]
				[$urandom_range(0, bhs_pkg::WAYS-1)];
		else if (pick < 75)
			key = compose_key(64'($urandom_range(0, 11)), $urandom_range(0, 3));
		else
			key = random_key();
		send_request(action, key);
	endtask

	// sender stops until every outstanding result has come back
	task automatic test_sender_pause();
		for (int i = 0; i < 5; i++)
			send_random_request();
		s_tvalid <= 1'b0;
		wait (pending_outcomes.size() == 0);
		@(negedge clk);
		for (int i = 0; i < 5; i++)
			send_random_request();
	endtask

	task automatic test_random_mix(int count);
		for (int i = 0; i < count; i++)
			send_random_request();
	endtask

	// empty the set with no stalls, then check it reads back empty
	task automatic test_drain_all();
		quiet = 1'b1;
		for (int b = 0; b < bhs_pkg::NUM_BUCKETS; b++)
			for (int w = 0; w < bhs_pkg::WAYS; w++)
				if (set_valid[b][w])
					send_request(bhs_pkg::ACT_REMOVE, set_keys[b][w]);
		send_request(bhs_pkg::ACT_LOOKUP, '0);
		send_request(bhs_pkg::ACT_LOOKUP, random_key());
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_receiver_holdoff();
		test_fill_to_capacity();
		test_random_mix(200);
		test_sender_pause();
		test_random_mix(200);
		test_drain_all();
		s_tvalid <= 1'b0;
		wait (pending_outcomes.size() == 0);
		repeat (20) @(posedge clk);
		if (pending_outcomes.size() != 0)
			errors++;
		$display("covered %0d requests and %0d results: %0d hits, %0d full-bucket drops",
			requests_sent, results_checked, hits_seen, drops_seen);
		$display("peak occupancy %0d of %0d slots, %0d mismatches",
			peak_held, bhs_pkg::SLOT_TOTAL, errors);
		if (errors == 0)
			$display("bucketed_hash_set_engine regression: pass");
		else
			$display("bucketed_hash_set_engine regression: fail");
		$finish;
	end

	// overall time limit
	initial begin
		#10_000_000;
		$display("bucketed_hash_set_engine regression: fail");
		$finish;
	end

endmodule
